FILE: rtl/core/mpssd_pkg.sv
package mpssd_pkg;

   localparam int DEF_MAX_PATCH_RADIUS = 7;
   localparam int DEF_COORD_BITS       = 12;

   localparam int RADIUS_W   = 3;
   localparam int RADIUS_MAX = (1 << RADIUS_W) - 1;
   localparam int SIZE_W     = 12;
   localparam int PIX_W      = 24;
   localparam int LIMIT_W    = 16;
   localparam int ACC_W      = 32;
   localparam int QUO_W      = 16;
   localparam int COST_W     = 18;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   // 3*255*255 = 65535 * 765 / 257
   localparam logic [COST_W-1:0] SAMPLE_MAX_COST = COST_W'(3 * 255 * 255);
   localparam int                CHAN_COST       = 765;
   localparam int                DIST_MUL        = 257;
   localparam int                DIST_MUL_W      = $clog2(DIST_MUL + 1);
   localparam logic [QUO_W-1:0]  DIST_SCALE      = QUO_W'(65535);

   localparam logic [RADIUS_W-1:0] RST_PATCH_RADIUS = RADIUS_W'(3);
   localparam logic [SIZE_W-1:0]   RST_IMAGE_SIZE   = SIZE_W'(512);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PATCH_RADIUS  = 3'd0,
      REG_SOURCE_HEIGHT = 3'd1,
      REG_SOURCE_WIDTH  = 3'd2,
      REG_TARGET_HEIGHT = 3'd3,
      REG_TARGET_WIDTH  = 3'd4
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_LOAD,
      ST_MULT,
      ST_CMP,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [RADIUS_W-1:0] radius;
      logic [SIZE_W-1:0]   src_height;
      logic [SIZE_W-1:0]   src_width;
      logic [SIZE_W-1:0]   tgt_height;
      logic [SIZE_W-1:0]   tgt_width;
   } cfg_type;

   typedef struct packed {
      logic acc;
      logic last;
      logic load;
      logic mult;
      logic cmp;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic over;
   } status_type;

endpackage

FILE: rtl/core/mpssd_csr.sv
module mpssd_csr
   import mpssd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_PATCH_RADIUS:  cfg_in.radius     = csr_wdata[RADIUS_W-1:0];
            REG_SOURCE_HEIGHT: cfg_in.src_height = csr_wdata[SIZE_W-1:0];
            REG_SOURCE_WIDTH:  cfg_in.src_width  = csr_wdata[SIZE_W-1:0];
            REG_TARGET_HEIGHT: cfg_in.tgt_height = csr_wdata[SIZE_W-1:0];
            REG_TARGET_WIDTH:  cfg_in.tgt_width  = csr_wdata[SIZE_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.radius     <= RST_PATCH_RADIUS;
         cfg_ff.src_height <= RST_IMAGE_SIZE;
         cfg_ff.src_width  <= RST_IMAGE_SIZE;
         cfg_ff.tgt_height <= RST_IMAGE_SIZE;
         cfg_ff.tgt_width  <= RST_IMAGE_SIZE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/core/mpssd_ctrl.sv
module mpssd_ctrl
   import mpssd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_last_sample,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int CNT_W = $clog2(QUO_W);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_ACCUM: begin
            if (req_valid && req_last_sample) state_in = ST_LOAD;
         end
         ST_LOAD:  state_in = ST_MULT;
         ST_MULT:  state_in = ST_CMP;
         ST_CMP:   state_in = status.over ? ST_DONE : ST_DIV;
         ST_DIV: begin
            if (cnt_ff == CNT_W'(QUO_W - 1)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) state_in = ST_ACCUM;
         end
         default:  state_in = ST_ACCUM;
      endcase
   end

   always_comb begin
      cmd          = '0;
      req_stall    = 1'b1;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_ACCUM: begin
            req_stall = 1'b0;
            cmd.acc   = req_valid;
            cmd.last  = req_valid && req_last_sample;
         end
         ST_LOAD:  cmd.load = 1'b1;
         ST_MULT:  cmd.mult = 1'b1;
         ST_CMP: begin
            cmd.cmp = 1'b1;
            cnt_in  = '0;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
         end
         ST_DONE: begin
            cmd.out_load = slot_free;
            if (slot_free) rsp_valid_in = 1'b1;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_last_starts_scale: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_last_sample) |=> state_ff == ST_LOAD)
      else $error("last sample did not start scaling");

   a_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> slot_free)
      else $error("result loaded over a pending one");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.acc, cmd.load, cmd.mult, cmd.cmp, cmd.div_step, cmd.out_load}))
      else $error("conflicting datapath commands");

   a_div_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP && !status.over) |=> (state_ff == ST_DIV && cnt_ff == '0))
      else $error("divide entered with stale count");

endmodule

FILE: rtl/core/mpssd_datapath.sv
module mpssd_datapath
   import mpssd_pkg::*;
#(
   parameter int MAX_PATCH_RADIUS = DEF_MAX_PATCH_RADIUS,
   parameter int COORD_BITS       = DEF_COORD_BITS
)(
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   output status_type                   status,
   input  cfg_type                      cfg,
   input  logic signed [COORD_BITS-1:0] req_src_row,
   input  logic signed [COORD_BITS-1:0] req_src_col,
   input  logic signed [COORD_BITS-1:0] req_tgt_row,
   input  logic signed [COORD_BITS-1:0] req_tgt_col,
   input  logic [PIX_W-1:0]             req_src_pixel,
   input  logic [PIX_W-1:0]             req_tgt_pixel,
   input  logic                         req_src_masked,
   input  logic                         req_tgt_masked,
   input  logic [LIMIT_W-1:0]           req_limit,
   output logic [QUO_W-1:0]             rsp_patch_distance,
   output logic                         rsp_over_limit
);

   localparam int EFF_RADIUS = (MAX_PATCH_RADIUS < RADIUS_MAX) ? MAX_PATCH_RADIUS : RADIUS_MAX;
   localparam int SIDE_MAX   = 2 * EFF_RADIUS + 1;
   localparam int AREA_MAX   = SIDE_MAX * SIDE_MAX;
   localparam int SIDE_W     = $clog2(SIDE_MAX + 1);
   localparam int AREA_W     = $clog2(AREA_MAX + 1);
   localparam int DEN_W      = $clog2(AREA_MAX * CHAN_COST + 1);
   localparam int NUM_W      = ACC_W + DIST_MUL_W;
   localparam int BND_W      = LIMIT_W + DEN_W;
   localparam int WIDE_W     = (NUM_W > BND_W) ? NUM_W : BND_W;
   localparam int CMP_W      = ((COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W) + 2;

   function automatic logic at_edge(input logic signed [COORD_BITS-1:0] v,
                                    input logic [SIZE_W-1:0] size);
      logic signed [CMP_W-1:0] vx;
      logic signed [CMP_W-1:0] sx;
      vx = CMP_W'(v);
      sx = signed'(CMP_W'(size));
      return (vx <= 0) || (vx >= sx - CMP_W'(1));
   endfunction

   function automatic logic [COST_W-1:0] sq_rgb(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
      logic signed [8:0]        d;
      logic signed [COST_W-1:0] dx;
      logic signed [COST_W-1:0] sq;
      logic [COST_W-1:0]        s;
      s = '0;
      for (int c = 0; c < 3; c++) begin
         d  = signed'({1'b0, a[8*c +: 8]}) - signed'({1'b0, b[8*c +: 8]});
         dx = COST_W'(d);
         sq = dx * dx;
         s  = s + unsigned'(sq);
      end
      return s;
   endfunction

   logic [ACC_W-1:0]    sum_ff;
   logic [ACC_W-1:0]    fin_ff;
   logic [LIMIT_W-1:0]  lim_ff;
   logic [DEN_W-1:0]    den_ff;
   logic [NUM_W-1:0]    num_ff;
   logic [BND_W-1:0]    bound_ff;
   logic [DEN_W-1:0]    rem_ff;
   logic [QUO_W-1:0]    quo_ff;
   logic                over_ff;
   logic [QUO_W-1:0]    dist_ff;
   logic                olim_ff;

   logic                edge_hit;
   logic [COST_W-1:0]   cost;
   logic [ACC_W:0]      total;
   logic [ACC_W-1:0]    total_sat;
   logic [RADIUS_W-1:0] r_eff;
   logic [SIDE_W-1:0]   side;
   logic [AREA_W-1:0]   area;
   logic [DEN_W-1:0]    den_in;
   logic                over;
   logic [DEN_W:0]      trial;
   logic                ge;

   assign edge_hit = at_edge(req_src_row, cfg.src_height) || at_edge(req_tgt_row, cfg.tgt_height)
                  || at_edge(req_src_col, cfg.src_width)  || at_edge(req_tgt_col, cfg.tgt_width);
   assign cost      = (edge_hit || req_src_masked || req_tgt_masked) ? SAMPLE_MAX_COST
                                                                     : sq_rgb(req_src_pixel,
                                                                              req_tgt_pixel);
   assign total     = {1'b0, sum_ff} + (ACC_W + 1)'(cost);
   assign total_sat = total[ACC_W] ? '1 : total[ACC_W-1:0];

   assign r_eff  = (cfg.radius > RADIUS_W'(EFF_RADIUS)) ? RADIUS_W'(EFF_RADIUS) : cfg.radius;
   assign side   = SIDE_W'({r_eff, 1'b1});
   assign area   = AREA_W'(side) * AREA_W'(side);
   assign den_in = DEN_W'(area) * DEN_W'(CHAN_COST);

   assign over        = WIDE_W'(num_ff) > WIDE_W'(bound_ff);
   assign status.over = over;

   assign trial = {rem_ff, quo_ff[QUO_W-1]};
   assign ge    = trial >= {1'b0, den_ff};

   assign rsp_patch_distance = dist_ff;
   assign rsp_over_limit     = olim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (cmd.acc) begin
         sum_ff <= cmd.last ? '0 : total_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.last) begin
         fin_ff <= total_sat;
         lim_ff <= req_limit;
      end
      if (cmd.load) begin
         den_ff <= den_in;
         num_ff <= (NUM_W'(fin_ff) << 8) + NUM_W'(fin_ff);
      end
      if (cmd.mult) begin
         bound_ff <= BND_W'(lim_ff) * BND_W'(den_ff);
      end
      // not over limit implies the quotient fits, so num >> 16 is below den
      if (cmd.cmp) begin
         over_ff <= over;
         rem_ff  <= num_ff[QUO_W +: DEN_W];
         quo_ff  <= num_ff[QUO_W-1:0];
      end
      if (cmd.div_step) begin
         rem_ff <= ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         quo_ff <= {quo_ff[QUO_W-2:0], ge};
      end
      if (cmd.out_load) begin
         dist_ff <= over_ff ? DIST_SCALE : quo_ff;
         olim_ff <= over_ff;
      end
   end

endmodule

FILE: rtl/core/masked_patch_ssd_distance_unit.sv
// Masked patch SSD distance. Feed one source/target sample pair per request;
// while a patch streams in, a request is taken every cycle. The request
// flagged last_sample closes the patch: the input then stalls while the sum
// is scaled (load, multiply, compare and, unless it exceeds the scaled limit,
// a one-bit-per-cycle restoring divider that produces the 16-bit distance).
// One response per patch is held in an output register; if it has not been
// taken when the next patch closes, the input stalls until it is. The user
// must write configuration through the csr port only while no patch is in
// flight; the block does not enforce this. csr_ready is always high.
module masked_patch_ssd_distance_unit
   import mpssd_pkg::*;
#(
   parameter int MAX_PATCH_RADIUS = DEF_MAX_PATCH_RADIUS,
   parameter int COORD_BITS       = DEF_COORD_BITS
)(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_src_row,
   input  logic signed [COORD_BITS-1:0] req_src_col,
   input  logic signed [COORD_BITS-1:0] req_tgt_row,
   input  logic signed [COORD_BITS-1:0] req_tgt_col,
   input  logic [PIX_W-1:0]             req_src_pixel,
   input  logic [PIX_W-1:0]             req_tgt_pixel,
   input  logic                         req_src_masked,
   input  logic                         req_tgt_masked,
   input  logic [LIMIT_W-1:0]           req_limit,
   input  logic                         req_last_sample,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [QUO_W-1:0]             rsp_patch_distance,
   output logic                         rsp_over_limit,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   mpssd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mpssd_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_last_sample (req_last_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .status          (status),
      .cmd             (cmd)
   );

   mpssd_datapath #(
      .MAX_PATCH_RADIUS (MAX_PATCH_RADIUS),
      .COORD_BITS       (COORD_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .cfg                (cfg),
      .req_src_row        (req_src_row),
      .req_src_col        (req_src_col),
      .req_tgt_row        (req_tgt_row),
      .req_tgt_col        (req_tgt_col),
      .req_src_pixel      (req_src_pixel),
      .req_tgt_pixel      (req_tgt_pixel),
      .req_src_masked     (req_src_masked),
      .req_tgt_masked     (req_tgt_masked),
      .req_limit          (req_limit),
      .rsp_patch_distance (rsp_patch_distance),
      .rsp_over_limit     (rsp_over_limit)
   );

endmodule
